// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, all clocked on the block clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- sv/polyc_pkg.sv -----
// ----------------------------------------------------------------------------
// polyc_pkg
// Widths, sequencer codes and the micro-op table of the corner detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package polyc_pkg;

   localparam int COORD_W    = 16;
   localparam int ID_W       = 10;
   localparam int THR_W      = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int MAG_W      = COORD_W;
   localparam int MUL_A_W    = 17;
   localparam int MUL_B_W    = 34;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int DOT_W      = 2 * COORD_W + 3;
   localparam int SQ_W       = 2 * COORD_W + 2;
   localparam int LHS_W      = 2 * SQ_W;
   localparam int PB_W       = 84;
   localparam int ACC_W      = 100;
   localparam int LHS_SHIFT  = 30;
   localparam int STEP_W     = 4;
   localparam int NUM_TESTS  = 3;
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;

   localparam logic signed [THR_W-1:0] THR_RESET = 16'sd16384;

   // Micro-op steps that end a phase of one test.
   localparam logic [STEP_W-1:0] CHECK_STEP = 4'd5;
   localparam logic [STEP_W-1:0] LAST_STEP  = 4'd14;

   // Bits of the pending-test mask, served from low to high.
   localparam int TB_INT   = 0;
   localparam int TB_LAST  = 1;
   localparam int TB_FIRST = 2;

   // Bits of the request sideband.
   localparam int RU_START  = 0;
   localparam int RU_CLOSED = 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_ACC,
      ST_CHECK,
      ST_CMP,
      ST_EMIT,
      ST_UPDATE
   } state_type;

   typedef enum logic [3:0] {
      A_UX, A_UY, A_VX, A_VY, A_ADOT_LO, A_ADOT_HI, A_SU_LO, A_SU_HI, A_THR
   } a_sel_type;

   typedef enum logic [3:0] {
      B_UX, B_UY, B_VX, B_VY, B_ADOT, B_SV, B_PA_LO, B_PA_HI,
      B_PB_LO, B_PB_MID, B_PB_HI
   } b_sel_type;

   typedef enum logic [2:0] {
      D_DOT, D_SU, D_SV, D_LHS, D_PA, D_PB
   } dest_type;

   typedef enum logic [1:0] {
      SH_0, SH_17, SH_34, SH_68
   } shift_type;

   typedef enum logic [1:0] {
      NEG_NONE, NEG_X, NEG_Y
   } neg_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      shift_type shift;
      dest_type  dest;
      neg_type   neg;
      logic      first;
   } uop_type;

   // One multiply-accumulate per step. The first step of a destination
   // overwrites it, later ones add the shifted partial product.
   function automatic uop_type uop_lookup(input logic [STEP_W-1:0] step);
      uop_type u;
      u = '{A_UX, B_VX, SH_0, D_DOT, NEG_X, 1'b1};
      case (step)
         4'd0:  u = '{A_UX,      B_VX,     SH_0,  D_DOT, NEG_X,    1'b1};
         4'd1:  u = '{A_UY,      B_VY,     SH_0,  D_DOT, NEG_Y,    1'b0};
         4'd2:  u = '{A_UX,      B_UX,     SH_0,  D_SU,  NEG_NONE, 1'b1};
         4'd3:  u = '{A_UY,      B_UY,     SH_0,  D_SU,  NEG_NONE, 1'b0};
         4'd4:  u = '{A_VX,      B_VX,     SH_0,  D_SV,  NEG_NONE, 1'b1};
         4'd5:  u = '{A_VY,      B_VY,     SH_0,  D_SV,  NEG_NONE, 1'b0};
         4'd6:  u = '{A_ADOT_LO, B_ADOT,   SH_0,  D_LHS, NEG_NONE, 1'b1};
         4'd7:  u = '{A_ADOT_HI, B_ADOT,   SH_17, D_LHS, NEG_NONE, 1'b0};
         4'd8:  u = '{A_SU_LO,   B_SV,     SH_0,  D_PA,  NEG_NONE, 1'b1};
         4'd9:  u = '{A_SU_HI,   B_SV,     SH_17, D_PA,  NEG_NONE, 1'b0};
         4'd10: u = '{A_THR,     B_PA_LO,  SH_0,  D_PB,  NEG_NONE, 1'b1};
         4'd11: u = '{A_THR,     B_PA_HI,  SH_34, D_PB,  NEG_NONE, 1'b0};
         4'd12: u = '{A_THR,     B_PB_LO,  SH_0,  D_PA,  NEG_NONE, 1'b1};
         4'd13: u = '{A_THR,     B_PB_MID, SH_34, D_PA,  NEG_NONE, 1'b0};
         4'd14: u = '{A_THR,     B_PB_HI,  SH_68, D_PA,  NEG_NONE, 1'b0};
         default: u = '{A_UX, B_VX, SH_0, D_DOT, NEG_X, 1'b1};
      endcase
      return u;
   endfunction

endpackage

// ----- sv/polyline_corner_detector_top.sv -----
// ----------------------------------------------------------------------------
// polyline_corner_detector_top
// Streams polyline points and flags corners by a cosine threshold test.
// ----------------------------------------------------------------------------
// Points of a curve arrive in order on the req_ stream, one word per point,
// with tlast on the last point of a curve and tuser carrying the start and
// closed marks. For every point with a neighbor on each side one result word
// leaves on the rsp_ stream: the tested point id, a corner flag in tuser and
// tlast on the last result of a curve. A closed curve of two or more points
// gives two more results on its last point (for the last point and for the
// first point), one of one point gives one; an open curve shorter than three
// points gives nothing. The threshold is a signed Q1.15 cosine written
// through csr_we/csr_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce; it resets to 0.5. Each angle
// test runs on one shared 17 x 34 bit multiplier with a 100 bit accumulator,
// stepped by a sequencer through fifteen multiply-accumulate micro-ops, each
// a multiply in ST_MUL and an accumulate in ST_ACC; a check after the sixth
// ends the test early when the signs decide it. req_tready is high only
// between points. A result sits in the output register until taken; while
// it is full and rsp_tready is low the sequencer holds at the next result
// and stops the input stream. Reset clears the sequencer, point count, closed
// mark, pending tests and output valid flag, and loads the default threshold.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module polyline_corner_detector_top (
   input  logic                              clock,
   input  logic                              reset,
   // Points
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // From bit 0: point_id[9:0], x_coord[15:0], y_coord[15:0], zero pad
   input  logic [polyc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                              req_tlast,   // curve_end
   // From bit 0: curve_start, closed_curve
   input  logic [polyc_pkg::REQ_USER_W-1:0]  req_tuser,
   // Results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // From bit 0: tested_id[9:0], zero pad
   output logic [polyc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,   // final_result
   output logic                              rsp_tuser,   // is_corner
   // Threshold register
   input  logic                              csr_we,
   input  logic [polyc_pkg::THR_W-1:0]       csr_wdata
);

   import polyc_pkg::*;

   // Sequencer
   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff;

   // Current point and curve bookkeeping
   logic signed [COORD_W-1:0] cur_x_ff, cur_y_ff;
   logic [ID_W-1:0]           cur_id_ff;
   logic                      end_ff;
   logic [1:0]                seen_ff;
   logic                      closed_ff;
   logic                      single_ff;
   logic [NUM_TESTS-1:0]      pend_ff;

   logic signed [COORD_W-1:0] win_x_ff [2];
   logic signed [COORD_W-1:0] win_y_ff [2];
   logic [ID_W-1:0]           win_id_ff [2];
   logic signed [COORD_W-1:0] head_x_ff [2];
   logic signed [COORD_W-1:0] head_y_ff [2];
   logic [ID_W-1:0]           head_id_ff [2];

   logic signed [THR_W-1:0]   thr_ff;

   // Arc components of the test in progress
   logic [MAG_W-1:0] uxm_ff, uym_ff, vxm_ff, vym_ff;
   logic             uxs_ff, uys_ff, vxs_ff, vys_ff;
   logic [ID_W-1:0]  tid_ff;
   logic             tfinal_ff;
   logic             res_ff;

   // Arithmetic registers
   logic [PROD_W-1:0]       prod_ff;
   logic signed [DOT_W-1:0] dot_ff;
   logic [SQ_W-1:0]         su_ff, sv_ff;
   logic [LHS_W-1:0]        lhs_ff;
   logic [ACC_W-1:0]        pa_ff;
   logic [PB_W-1:0]         pb_ff;

   // Output register
   logic            rsp_valid_ff;
   logic [ID_W-1:0] rsp_id_ff;
   logic            rsp_corner_ff, rsp_last_ff;

   // Control strobes
   logic accept, do_load, do_mul, do_acc, do_check, do_cmp, do_update;
   logic emit_go;

   // Request fields
   logic [ID_W-1:0]           in_id;
   logic signed [COORD_W-1:0] in_x, in_y;
   logic [1:0]                eff_seen;
   logic                      eff_closed;
   logic [NUM_TESTS-1:0]      pend_in;

   // Test selection
   logic [NUM_TESTS-1:0]      cur_bit, pend_rest;
   logic signed [COORD_W-1:0] pa_x, pa_y, pb_x, pb_y, pc_x, pc_y;
   logic [ID_W-1:0]           sel_id;
   logic signed [DIFF_W-1:0]  ux, uy, vx, vy;
   logic [DIFF_W-1:0]         uxa, uya, vxa, vya;

   // Multiply-accumulate
   uop_type                   uop;
   logic [DOT_W-1:0]          adot_full;
   logic [SQ_W-1:0]           adot;
   logic [THR_W:0]            thr_abs;
   logic [MUL_A_W-1:0]        mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic [ACC_W-1:0]          prod_ext, shifted, addend, base, sum;
   logic                      neg_now;

   // Decisions
   logic thr_neg, zero_arc, dot_neg, dot_zero, decided;
   logic [ACC_W-1:0] lhs_scaled;

   assign in_id = req_tdata[ID_W-1:0];
   assign in_x  = req_tdata[ID_W +: COORD_W];
   assign in_y  = req_tdata[ID_W + COORD_W +: COORD_W];

   // A start mark restarts the curve count; the closed mark is read on the
   // first point of a curve only.
   assign eff_seen   = req_tuser[RU_START] ? 2'd0 : seen_ff;
   assign eff_closed = (eff_seen == 2'd0) ? req_tuser[RU_CLOSED] : closed_ff;

   always_comb begin
      pend_in = '0;
      pend_in[TB_INT] = eff_seen[1];
      if (req_tlast && eff_closed) begin
         pend_in[TB_LAST]  = 1'b1;
         pend_in[TB_FIRST] = (eff_seen != 2'd0);
      end
   end

   // Lowest pending test goes first: interior, then last, then first point.
   assign cur_bit   = pend_ff & (~pend_ff + NUM_TESTS'(1));
   assign pend_rest = pend_ff & ~cur_bit;

   always_comb begin
      pa_x = cur_x_ff;  pa_y = cur_y_ff;
      pb_x = cur_x_ff;  pb_y = cur_y_ff;
      pc_x = cur_x_ff;  pc_y = cur_y_ff;
      sel_id = cur_id_ff;
      if (cur_bit[TB_INT]) begin
         pa_x = win_x_ff[0];  pa_y = win_y_ff[0];
         pb_x = win_x_ff[1];  pb_y = win_y_ff[1];
         sel_id = win_id_ff[1];
      end else if (cur_bit[TB_LAST]) begin
         // A closed curve of one point tests that point against itself.
         if (!single_ff) begin
            pa_x = win_x_ff[1];   pa_y = win_y_ff[1];
            pc_x = head_x_ff[0];  pc_y = head_y_ff[0];
         end
      end else begin
         pb_x = head_x_ff[0];  pb_y = head_y_ff[0];
         if (seen_ff[1]) begin
            pc_x = head_x_ff[1];  pc_y = head_y_ff[1];
         end
         sel_id = head_id_ff[0];
      end
   end

   assign ux  = {pa_x[COORD_W-1], pa_x} - {pb_x[COORD_W-1], pb_x};
   assign uy  = {pa_y[COORD_W-1], pa_y} - {pb_y[COORD_W-1], pb_y};
   assign vx  = {pc_x[COORD_W-1], pc_x} - {pb_x[COORD_W-1], pb_x};
   assign vy  = {pc_y[COORD_W-1], pc_y} - {pb_y[COORD_W-1], pb_y};
   assign uxa = ux[DIFF_W-1] ? -ux : ux;
   assign uya = uy[DIFF_W-1] ? -uy : uy;
   assign vxa = vx[DIFF_W-1] ? -vx : vx;
   assign vya = vy[DIFF_W-1] ? -vy : vy;

   // Operand selection for the shared multiplier.
   assign uop       = uop_lookup(step_ff);
   assign adot_full = dot_ff[DOT_W-1] ? -dot_ff : dot_ff;
   assign adot      = adot_full[SQ_W-1:0];
   assign thr_abs   = thr_ff[THR_W-1] ? -{thr_ff[THR_W-1], thr_ff} : {1'b0, thr_ff};

   always_comb begin
      case (uop.a_sel)
         A_UX:      mul_a = MUL_A_W'(uxm_ff);
         A_UY:      mul_a = MUL_A_W'(uym_ff);
         A_VX:      mul_a = MUL_A_W'(vxm_ff);
         A_VY:      mul_a = MUL_A_W'(vym_ff);
         A_ADOT_LO: mul_a = adot[MUL_A_W-1:0];
         A_ADOT_HI: mul_a = adot[SQ_W-1:MUL_A_W];
         A_SU_LO:   mul_a = su_ff[MUL_A_W-1:0];
         A_SU_HI:   mul_a = su_ff[SQ_W-1:MUL_A_W];
         A_THR:     mul_a = MUL_A_W'(thr_abs);
         default:   mul_a = '0;
      endcase
   end

   always_comb begin
      case (uop.b_sel)
         B_UX:     mul_b = MUL_B_W'(uxm_ff);
         B_UY:     mul_b = MUL_B_W'(uym_ff);
         B_VX:     mul_b = MUL_B_W'(vxm_ff);
         B_VY:     mul_b = MUL_B_W'(vym_ff);
         B_ADOT:   mul_b = adot;
         B_SV:     mul_b = sv_ff;
         B_PA_LO:  mul_b = pa_ff[MUL_B_W-1:0];
         B_PA_HI:  mul_b = pa_ff[2*MUL_B_W-1:MUL_B_W];
         B_PB_LO:  mul_b = pb_ff[MUL_B_W-1:0];
         B_PB_MID: mul_b = pb_ff[2*MUL_B_W-1:MUL_B_W];
         B_PB_HI:  mul_b = MUL_B_W'(pb_ff[PB_W-1:2*MUL_B_W]);
         default:  mul_b = '0;
      endcase
   end

   // Accumulate stage: shift the registered product into place and add it
   // to the destination, or load it on the first step of that destination.
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      case (uop.shift)
         SH_0:    shifted = prod_ext;
         SH_17:   shifted = prod_ext << 17;
         SH_34:   shifted = prod_ext << 34;
         SH_68:   shifted = prod_ext << 68;
         default: shifted = prod_ext;
      endcase
   end

   always_comb begin
      case (uop.neg)
         NEG_X:   neg_now = uxs_ff ^ vxs_ff;
         NEG_Y:   neg_now = uys_ff ^ vys_ff;
         default: neg_now = 1'b0;
      endcase
   end

   always_comb begin
      case (uop.dest)
         D_DOT:   base = {{(ACC_W-DOT_W){dot_ff[DOT_W-1]}}, dot_ff};
         D_SU:    base = ACC_W'(su_ff);
         D_SV:    base = ACC_W'(sv_ff);
         D_LHS:   base = ACC_W'(lhs_ff);
         D_PA:    base = pa_ff;
         D_PB:    base = ACC_W'(pb_ff);
         default: base = '0;
      endcase
   end

   assign addend = neg_now ? -shifted : shifted;
   assign sum    = (uop.first ? '0 : base) + addend;

   // Sign checks settle most tests; a zero-length arc counts as cosine 0.
   // Whenever they settle it, the answer equals the threshold's sign.
   assign thr_neg  = thr_ff[THR_W-1];
   assign zero_arc = (su_ff == '0) || (sv_ff == '0);
   assign dot_neg  = dot_ff[DOT_W-1];
   assign dot_zero = (dot_ff == '0);
   assign decided  = zero_arc || (!thr_neg && (dot_neg || dot_zero)) ||
                     (thr_neg && !dot_neg);

   // dot^2 * 2^30 against T^2 * |u|^2 * |v|^2.
   assign lhs_scaled = ACC_W'(lhs_ff) << LHS_SHIFT;

   assign emit_go = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (pend_in != '0) ? ST_LOAD : ST_UPDATE;
            end
         end
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC: begin
            if (step_ff == CHECK_STEP) begin
               state_in = ST_CHECK;
            end else if (step_ff == LAST_STEP) begin
               state_in = ST_CMP;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_CHECK: state_in = decided ? ST_EMIT : ST_MUL;
         ST_CMP:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go) begin
               state_in = (pend_rest != '0) ? ST_LOAD : ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      do_load    = 1'b0;
      do_mul     = 1'b0;
      do_acc     = 1'b0;
      do_check   = 1'b0;
      do_cmp     = 1'b0;
      do_update  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_LOAD:   do_load    = 1'b1;
         ST_MUL:    do_mul     = 1'b1;
         ST_ACC:    do_acc     = 1'b1;
         ST_CHECK:  do_check   = 1'b1;
         ST_CMP:    do_cmp     = 1'b1;
         ST_UPDATE: do_update  = 1'b1;
         default:   req_tready = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= 2'd0;
         closed_ff    <= 1'b0;
         pend_ff      <= '0;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (accept) begin
            seen_ff   <= eff_seen;
            closed_ff <= eff_closed;
            pend_ff   <= pend_in;
         end
         if (state_ff == ST_EMIT && emit_go) begin
            pend_ff      <= pend_rest;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (do_update) begin
            if (end_ff) begin
               seen_ff <= 2'd0;
            end else if (seen_ff != 2'd3) begin
               seen_ff <= seen_ff + 2'd1;
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_x_ff  <= in_x;
         cur_y_ff  <= in_y;
         cur_id_ff <= in_id;
         end_ff    <= req_tlast;
         single_ff <= (eff_seen == 2'd0);
      end
      if (do_load) begin
         uxm_ff    <= uxa[MAG_W-1:0];
         uym_ff    <= uya[MAG_W-1:0];
         vxm_ff    <= vxa[MAG_W-1:0];
         vym_ff    <= vya[MAG_W-1:0];
         uxs_ff    <= ux[DIFF_W-1];
         uys_ff    <= uy[DIFF_W-1];
         vxs_ff    <= vx[DIFF_W-1];
         vys_ff    <= vy[DIFF_W-1];
         tid_ff    <= sel_id;
         tfinal_ff <= end_ff && (pend_rest == '0);
         step_ff   <= '0;
      end
      if (do_mul) begin
         prod_ff <= mul_a * mul_b;
      end
      if (do_acc) begin
         step_ff <= step_ff + STEP_W'(1);
         case (uop.dest)
            D_DOT:   dot_ff <= sum[DOT_W-1:0];
            D_SU:    su_ff  <= sum[SQ_W-1:0];
            D_SV:    sv_ff  <= sum[SQ_W-1:0];
            D_LHS:   lhs_ff <= sum[LHS_W-1:0];
            D_PA:    pa_ff  <= sum;
            D_PB:    pb_ff  <= sum[PB_W-1:0];
            default: pa_ff  <= pa_ff;
         endcase
      end
      if (do_check) begin
         res_ff <= thr_neg;
      end
      if (do_cmp) begin
         res_ff <= thr_neg ? (lhs_scaled < pa_ff) : (lhs_scaled > pa_ff);
      end
      if (state_ff == ST_EMIT && emit_go) begin
         rsp_id_ff     <= tid_ff;
         rsp_corner_ff <= res_ff;
         rsp_last_ff   <= tfinal_ff;
      end
      if (do_update) begin
         if (!seen_ff[1]) begin
            head_x_ff[seen_ff[0]]  <= cur_x_ff;
            head_y_ff[seen_ff[0]]  <= cur_y_ff;
            head_id_ff[seen_ff[0]] <= cur_id_ff;
         end
         win_x_ff[0]  <= win_x_ff[1];
         win_y_ff[0]  <= win_y_ff[1];
         win_id_ff[0] <= win_id_ff[1];
         win_x_ff[1]  <= cur_x_ff;
         win_y_ff[1]  <= cur_y_ff;
         win_id_ff[1] <= cur_id_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_id_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_corner_ff;

   // A point is taken only between points.
   `ASSERT_CLK(a_one_point_at_a_time, (req_tvalid && req_tready) |=> !req_tready,
      "point accepted while the previous one is still in progress")

   // The last-point test of a curve longer than one point always comes with
   // a first-point test still queued behind it.
   `ASSERT_CLK(a_last_then_first, (pend_ff[TB_LAST] && !single_ff) |-> pend_ff[TB_FIRST],
      "last-point test queued without its first-point test")

   // A one-point closed curve gets a single test only.
   `ASSERT_CLK(a_single_alone, single_ff && pend_ff[TB_LAST] |-> !pend_ff[TB_FIRST],
      "one-point curve queued a first-point test")

   // The final result of a curve leaves no test behind.
   `ASSERT_CLK(a_final_drains, (state_ff == ST_EMIT && emit_go && tfinal_ff) |=> pend_ff == '0,
      "final result sent while tests are still pending")

   // Results enter the output register only from the emit state.
   `ASSERT_CLK_ALWAYS(a_rsp_from_emit, $rose(rsp_tvalid) |-> $past(state_ff == ST_EMIT),
      "result word appeared outside the emit state")

endmodule

// ----- dv/tb_polyline_corner_detector_top.sv -----
// ----------------------------------------------------------------------------
// tb_polyline_corner_detector_top
// Self-checking bench for the streaming polyline corner detector.
// ----------------------------------------------------------------------------
// Points are sent as words on the req_ stream. On every accepted point, a
// cycle-free model of the curve state predicts the result words that the
// point causes, and a monitor compares each rsp_ word with the oldest
// prediction. A short table of hand-built curves comes first: short open
// curves, straight and sharp turns, closed curves of one to four points,
// zero-length arcs, and missing or repeated start marks. Random curves then
// run under several thresholds, the extremes among them, with the sender and
// the receiver idling at different rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_polyline_corner_detector_top;

   import polyc_pkg::*;

   localparam int NO_PIN          = -1;
   localparam int DRAIN_CYCLES    = 200;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int POINTS_PER_RUN  = 56;
   localparam int NUM_THR_RUNS    = 6;

   typedef struct {
      logic [ID_W-1:0]           id;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      bit                        start;
      bit                        last;
      bit                        closed;
   } point_type;

   typedef struct {
      logic [ID_W-1:0] id;
      bit              corner;
      bit              last;
   } corner_result_type;

   // A directed row may pin the number of results and their corner flags
   // (bit k for the k-th result); pin_n of NO_PIN leaves it to the predictor.
   typedef struct {
      point_type pt;
      int        pin_n;
      bit [2:0]  pin_corner;
   } directed_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tlast;
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_we;
   logic [THR_W-1:0]       csr_wdata;

   polyline_corner_detector_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Predictor copy of the curve state: the two newest points, the first two
   // points of the curve, the point count and the closed mark.
   longint          trail_x[2], trail_y[2];
   logic [ID_W-1:0] trail_id[2];
   longint          lead_x[2], lead_y[2];
   logic [ID_W-1:0] lead_id[2];
   int              pts_in_curve;
   bit              curve_closed;
   longint          thr_now;

   corner_result_type corner_q[$];

   int  req_idle_pct;
   int  rsp_stall_pct;
   int  errors = 0;
   int  cycle_count = 0;
   int  points_sent;
   int  curves_sent;
   int  results_seen = 0;
   int  corners_seen = 0;
   int  thr_settings;

   directed_row_type directed_rows[26] = '{
      // Open curves of one and two points give nothing.
      '{'{10'd0,    16'sd0,      16'sd0,     1'b1, 1'b1, 1'b0}, 0, 3'b000},
      '{'{10'd1,    16'sd0,      16'sd0,     1'b1, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd2,    16'sd16,     16'sd0,     1'b0, 1'b1, 1'b0}, 0, 3'b000},
      // Straight line: cosine -1, no corner.
      '{'{10'd3,    16'sd0,      16'sd0,     1'b1, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd4,    16'sd16,     16'sd0,     1'b0, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd5,    16'sd32,     16'sd0,     1'b0, 1'b1, 1'b0}, 1, 3'b000},
      // Turn back almost onto itself: cosine near +1, a corner.
      '{'{10'd6,    16'sd0,      16'sd0,     1'b1, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd7,    16'sd100,    16'sd0,     1'b0, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd8,    16'sd0,      16'sd1,     1'b0, 1'b1, 1'b0}, 1, 3'b001},
      // Closed curve of one point at the coordinate extremes: both arcs zero.
      '{'{10'd1023, 16'sh8000,   16'sh7FFF,  1'b1, 1'b1, 1'b1}, 1, 3'b000},
      // Closed curve of two points: both arcs coincide, cosine +1.
      '{'{10'd10,   16'sd0,      16'sd0,     1'b1, 1'b0, 1'b1}, 0, 3'b000},
      '{'{10'd11,   16'sd48,     -16'sd48,   1'b0, 1'b1, 1'b0}, 2, 3'b011},
      // Closed square spanning the full range: right angles everywhere.
      '{'{10'd12,   16'sh8000,   16'sh8000,  1'b1, 1'b0, 1'b1}, 0, 3'b000},
      '{'{10'd13,   16'sh7FFF,   16'sh8000,  1'b0, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd14,   16'sh7FFF,   16'sh7FFF,  1'b0, 1'b0, 1'b0}, 1, 3'b000},
      '{'{10'd15,   16'sh8000,   16'sh7FFF,  1'b0, 1'b1, 1'b0}, 3, 3'b000},
      // No start mark after an end: a new closed triangle begins anyway.
      '{'{10'd16,   16'sd0,      16'sd0,     1'b0, 1'b0, 1'b1}, 0, 3'b000},
      '{'{10'd17,   16'sd32,     16'sd0,     1'b0, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd18,   16'sd0,      16'sd32,    1'b0, 1'b1, 1'b0}, NO_PIN, 3'b000},
      // Repeated point: a zero-length arc counts as cosine 0.
      '{'{10'd19,   16'sd5,      16'sd5,     1'b1, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd20,   16'sd5,      16'sd5,     1'b0, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd21,   16'sd9,      16'sd9,     1'b0, 1'b1, 1'b0}, 1, 3'b000},
      // A start mark in mid-curve drops the unfinished curve.
      '{'{10'd22,   16'sd0,      16'sd0,     1'b1, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd23,   16'sd10,     16'sd10,    1'b0, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd24,   16'sd0,      16'sd0,     1'b1, 1'b0, 1'b0}, 0, 3'b000},
      '{'{10'd25,   -16'sd16,    16'sd3,     1'b0, 1'b1, 1'b0}, 0, 3'b000}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // The receiver stalls at random; the rate changes between runs.
   always @(negedge clock)
      rsp_tready <= reset ? 1'b0 : ($urandom_range(0, 99) >= rsp_stall_pct);

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
   endtask

   // Exact cosine test at (bx, by). The sign of the dot product settles most
   // cases; otherwise dot^2 * 2^30 is weighed against T^2 * |u|^2 * |v|^2.
   function automatic bit angle_is_sharp(input longint ax, input longint ay,
                                         input longint bx, input longint by,
                                         input longint cx, input longint cy);
      longint       ux, uy, vx, vy, dot_uv;
      logic [127:0] len_u, len_v, dot_mag, thr_sq, lhs, rhs;
      ux = ax - bx;
      uy = ay - by;
      vx = cx - bx;
      vy = cy - by;
      dot_uv = ux * vx + uy * vy;
      len_u = ux * ux + uy * uy;
      len_v = vx * vx + vy * vy;
      if (len_u == 0 || len_v == 0)
         return thr_now < 0;
      if (thr_now >= 0 && dot_uv <= 0)
         return 1'b0;
      if (thr_now < 0 && dot_uv >= 0)
         return 1'b1;
      dot_mag = (dot_uv < 0) ? -dot_uv : dot_uv;
      thr_sq  = thr_now * thr_now;
      lhs = (dot_mag * dot_mag) << LHS_SHIFT;
      rhs = len_u * len_v * thr_sq;
      if (thr_now >= 0)
         return lhs > rhs;
      return lhs < rhs;
   endfunction

   // Advances the curve state by one point and returns the result words it
   // causes, in the order the block sends them.
   function automatic void predict_point(input point_type pt,
                                         output corner_result_type outs[3],
                                         output int n);
      longint px, py, nx, ny;
      px = pt.x;
      py = pt.y;
      n = 0;
      if (pt.start)
         pts_in_curve = 0;
      if (pts_in_curve == 0)
         curve_closed = pt.closed;

      if (pts_in_curve >= 2) begin
         outs[n].id     = trail_id[1];
         outs[n].corner = angle_is_sharp(trail_x[0], trail_y[0], trail_x[1], trail_y[1],
                                         px, py);
         n++;
      end

      if (pt.last && curve_closed) begin
         if (pts_in_curve == 0) begin
            outs[n].id     = pt.id;
            outs[n].corner = angle_is_sharp(px, py, px, py, px, py);
            n++;
         end else begin
            // A two-point curve has no second head yet; the new point serves.
            nx = (pts_in_curve >= 2) ? lead_x[1] : px;
            ny = (pts_in_curve >= 2) ? lead_y[1] : py;
            outs[n].id     = pt.id;
            outs[n].corner = angle_is_sharp(trail_x[1], trail_y[1], px, py,
                                            lead_x[0], lead_y[0]);
            n++;
            outs[n].id     = lead_id[0];
            outs[n].corner = angle_is_sharp(px, py, lead_x[0], lead_y[0], nx, ny);
            n++;
         end
      end

      for (int k = 0; k < n; k++)
         outs[k].last = pt.last && (k == n - 1);

      if (pts_in_curve < 2) begin
         lead_x[pts_in_curve]  = px;
         lead_y[pts_in_curve]  = py;
         lead_id[pts_in_curve] = pt.id;
      end
      trail_x[0]  = trail_x[1];
      trail_y[0]  = trail_y[1];
      trail_id[0] = trail_id[1];
      trail_x[1]  = px;
      trail_y[1]  = py;
      trail_id[1] = pt.id;

      if (pt.last)
         pts_in_curve = 0;
      else if (pts_in_curve < 3)
         pts_in_curve++;
   endfunction

   // Offers one point word, holds it until accepted, then predicts from it.
   task automatic send_point(input point_type pt, input int pin_n,
                             input bit [2:0] pin_corner);
      corner_result_type outs[3];
      int                n;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - ID_W - 2 * COORD_W){1'b0}}, pt.y, pt.x, pt.id};
      req_tlast  <= pt.last;
      req_tuser  <= {pt.closed, pt.start};
      do @(posedge clock); while (!req_tready);

      predict_point(pt, outs, n);
      if (pin_n != NO_PIN) begin
         if (n != pin_n)
            report_mismatch($sformatf("point %0d predicts %0d results, table says %0d",
                                      pt.id, n, pin_n));
         for (int k = 0; k < n && k < pin_n; k++)
            if (outs[k].corner != pin_corner[k])
               report_mismatch($sformatf("point %0d result %0d corner %0b, table says %0b",
                                         pt.id, k, outs[k].corner, pin_corner[k]));
      end
      for (int k = 0; k < n; k++)
         corner_q.insert(corner_q.size(), outs[k]);
      points_sent++;
   endtask

   // One random curve. Most are well formed; some lack the start mark, end
   // early, restart mid-way or repeat points so that arcs vanish.
   task automatic send_random_curve();
      point_type                 pt;
      int                        len, mode, cut_at, pick;
      logic [ID_W-1:0]           id_base;
      logic signed [COORD_W-1:0] base_x, base_y;
      bit                        closed;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         len = $urandom_range(3, 6);
      else if (pick < 85)
         len = $urandom_range(1, 2);
      else
         len = $urandom_range(7, 12);
      mode    = $urandom_range(0, 2);
      id_base = ID_W'($urandom_range(0, 1023));
      base_x  = COORD_W'($urandom);
      base_y  = COORD_W'($urandom);
      closed  = bit'($urandom_range(0, 1));
      cut_at  = ($urandom_range(0, 99) < 8) ? $urandom_range(1, len) : len + 1;
      pt.x = base_x;
      pt.y = base_y;
      for (int k = 0; k < len && k < cut_at; k++) begin
         pt.id = id_base + k[ID_W-1:0];
         if (k == 0 || $urandom_range(0, 99) >= 12) begin
            case (mode)
               0: begin
                  pt.x = COORD_W'($urandom);
                  pt.y = COORD_W'($urandom);
               end
               1: begin
                  pt.x = base_x + COORD_W'($urandom_range(0, 127)) - 16'sd64;
                  pt.y = base_y + COORD_W'($urandom_range(0, 127)) - 16'sd64;
               end
               default: begin
                  pt.x = COORD_W'($urandom_range(0, 255)) - 16'sd128;
                  pt.y = COORD_W'($urandom_range(0, 255)) - 16'sd128;
               end
            endcase
         end
         pt.start  = (k == 0) ? ($urandom_range(0, 99) < 90) : ($urandom_range(0, 99) < 3);
         pt.last   = (k == len - 1) || ($urandom_range(0, 99) < 3);
         pt.closed = (k == 0) ? closed : bit'($urandom_range(0, 1));
         send_point(pt, NO_PIN, 3'b000);
         if (pt.last)
            break;
      end
      curves_sent++;
   endtask

   task automatic write_threshold(input logic signed [THR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      thr_now    = value;
      @(negedge clock);
      csr_we    <= 1'b0;
      thr_settings++;
   endtask

   // Lets every predicted word arrive, then waits out any point still being
   // worked on that causes no result.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (corner_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      corner_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser)
            corners_seen++;
         if (corner_q.size() == 0) begin
            report_mismatch($sformatf("result word for id %0d with nothing expected",
                                      rsp_tdata[ID_W-1:0]));
         end else begin
            want = corner_q.pop_front();
            if (rsp_tdata[ID_W-1:0] !== want.id)
               report_mismatch($sformatf("tested id %0d, expected %0d",
                                         rsp_tdata[ID_W-1:0], want.id));
            if (rsp_tuser !== want.corner)
               report_mismatch($sformatf("id %0d corner flag %b, expected %b",
                                         want.id, rsp_tuser, want.corner));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("id %0d final flag %b, expected %b",
                                         want.id, rsp_tlast, want.last));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, corner_q.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic signed [THR_W-1:0] thr_plan[NUM_THR_RUNS];
      int                      run_start;
      // Drive every input to a known value before the first edge.
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      req_tuser     = '0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      points_sent   = 0;
      curves_sent   = 0;
      thr_settings  = 1;
      req_idle_pct  = 16;
      rsp_stall_pct = 46;
      thr_now       = THR_RESET;
      pts_in_curve  = 0;
      curve_closed  = 1'b0;
      for (int k = 0; k < 2; k++) begin
         trail_x[k] = 0; trail_y[k] = 0; trail_id[k] = '0;
         lead_x[k]  = 0; lead_y[k]  = 0; lead_id[k]  = '0;
      end

      thr_plan[0] = 16'sh7FFF;
      thr_plan[1] = 16'sh8000;
      thr_plan[2] = 16'sd0;
      thr_plan[3] = -16'sd16384;
      thr_plan[4] = THR_W'($urandom);
      thr_plan[5] = THR_W'($urandom);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hand-built curves under the reset threshold of 0.5.
      foreach (directed_rows[i])
         send_point(directed_rows[i].pt, directed_rows[i].pin_n, directed_rows[i].pin_corner);
      wait_idle();

      // Random curves: two runs with a slow receiver, two with a slow sender,
      // then two at full rate on both sides.
      for (int s = 0; s < NUM_THR_RUNS; s++) begin
         req_idle_pct  = (s < 2) ? 16 : ((s < 4) ? 46 : 0);
         rsp_stall_pct = (s < 2) ? 46 : ((s < 4) ? 16 : 0);
         write_threshold(thr_plan[s]);
         run_start = points_sent;
         while (points_sent - run_start < POINTS_PER_RUN)
            send_random_curve();
         wait_idle();
      end

      $display("Sent %0d points (%0d random curves) under %0d threshold settings.",
               points_sent, curves_sent, thr_settings);
      $display("Checked %0d result words, %0d of them corners; %0d mismatches.",
               results_seen, corners_seen, errors);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/polyc_pkg.sv
sv/polyline_corner_detector_top.sv
dv/tb_polyline_corner_detector_top.sv
